### hdl/tsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the time series resampler.
// Holds the request payload structs and the register indexes.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_MASK  = 2'd3;

    typedef struct packed {
        logic signed [31:0] in_offset;
        logic        [15:0] in_co2;
        logic signed [15:0] in_temp;
        logic        [15:0] in_humidity;
        logic signed [15:0] in_voc;
        logic signed [15:0] in_nox;
        logic        [17:0] in_pressure;
        logic signed [15:0] in_pm;
        logic               in_last;
    } in_rec_t;

    typedef struct packed {
        logic signed [31:0] out_offset;
        logic        [15:0] out_co2;
        logic signed [15:0] out_temp;
        logic        [15:0] out_humidity;
        logic signed [15:0] out_voc;
        logic signed [15:0] out_nox;
        logic        [17:0] out_pressure;
        logic signed [15:0] out_pm;
        logic               out_end_marker;
        logic               out_final;
    } out_rec_t;

endpackage
`default_nettype wire

### hdl/time_series_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_series_resampler: linear interpolation resampler.
// Resamples time-ordered sensor records onto a regular grid of points.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  tsr_pkg::in_rec_t
// out       output     out_valid/out_ready tsr_pkg::out_rec_t
// cfg       input      cfg_we             cfg_index, cfg_data
//
// A record that closes no bracket keeps in_ready low after it is taken, while it
// passes the check, tail, end-marker and wait states. Each interpolated point
// passes a check, the restoring weight divider, the shared 20x(WEIGHT_BITS+2)
// multiplier at one field a cycle, and an emit state. Multiply and emit wait
// while the output register holds an untaken result, and in_ready stays low
// until it is taken. Reset clears all control state and loads register defaults.
// ----------------------------------------------------------------------------
module time_series_resampler #(
    parameter int MAX_POINTS  = tsr_pkg::MAX_POINTS_DEF,
    parameter int WEIGHT_BITS = tsr_pkg::WEIGHT_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  tsr_pkg::in_rec_t    in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output tsr_pkg::out_rec_t   out_data,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data
);
    import tsr_pkg::*;

    localparam int WB = WEIGHT_BITS;
    localparam int CW = $clog2(WB);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_EMIT  = 8'b0001_0000,
        ST_TAIL  = 8'b0010_0000,
        ST_ENDM  = 8'b0100_0000,
        ST_WAIT  = 8'b1000_0000
    } state_t;

    // Configuration registers.
    logic signed [31:0] start_reg;
    logic [16:0]        step_reg;
    logic [6:0]         count_reg;
    logic [15:0]        mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            step_reg  <= 17'd60;
            count_reg <= 7'd64;
            mask_reg  <= 16'd511;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START: start_reg <= cfg_data;
                REG_STEP:  step_reg  <= cfg_data[16:0];
                REG_COUNT: count_reg <= cfg_data[6:0];
                REG_MASK:  mask_reg  <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    state_t             state_reg;
    in_rec_t            rec_reg;
    in_rec_t            held_reg;
    logic               have_held_reg;
    logic               done_reg;
    logic signed [32:0] npo_reg;
    logic [6:0]         emitted_reg;
    logic               any_reg;
    out_rec_t           obuf_reg;
    logic               ovalid_reg;

    // Divider state: restoring, one quotient bit a cycle.
    logic [32:0]        drem_reg;
    logic [32:0]        dden_reg;
    logic [WB:0]        quo_reg;
    logic [CW-1:0]      dcnt_reg;
    logic [2:0]         fidx_reg;

    // Effective count and step.
    logic [6:0]         cnt_eff;
    logic [16:0]        stp_eff;
    assign cnt_eff = (count_reg > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : count_reg;
    assign stp_eff = (step_reg == '0) ? 17'd1 : step_reg;

    logic signed [32:0] roff;
    logic signed [32:0] hoff;
    logic signed [32:0] start_ext;
    assign roff      = {rec_reg.in_offset[31], rec_reg.in_offset};
    assign hoff      = {held_reg.in_offset[31], held_reg.in_offset};
    assign start_ext = $signed({start_reg[31], start_reg});

    // Shared multiply: field difference times weight, truncated toward zero.
    logic signed [18:0] ma, mb;
    logic signed [19:0] mdiff;
    logic signed [20+WB:0] mprod;
    logic signed [20+WB:0] mq;
    logic signed [19:0] mres;
    logic [15:0] gmask;
    logic gzero;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (fidx_reg)
            3'd0: begin ma = 19'(held_reg.in_co2); mb = 19'(rec_reg.in_co2); end
            3'd1: begin ma = 19'(held_reg.in_temp); mb = 19'(rec_reg.in_temp); end
            3'd2: begin ma = 19'(held_reg.in_humidity); mb = 19'(rec_reg.in_humidity); end
            3'd3:
            begin
                ma = 19'($signed(held_reg.in_voc & mask_reg));
                mb = 19'($signed(rec_reg.in_voc & mask_reg));
            end
            3'd4:
            begin
                ma = 19'($signed(held_reg.in_nox & mask_reg));
                mb = 19'($signed(rec_reg.in_nox & mask_reg));
            end
            3'd5: begin ma = 19'(held_reg.in_pressure); mb = 19'(rec_reg.in_pressure); end
            3'd6: begin ma = 19'(held_reg.in_pm); mb = 19'(rec_reg.in_pm); end
            default: ;
        endcase
        mdiff = 20'(mb) - 20'(ma);
        mprod = (21+WB)'(mdiff) * $signed({1'b0, quo_reg});
        mq    = (mprod < 0) ? -((-mprod) >>> WB) : (mprod >>> WB);
        mres  = 20'(ma) + mq[19:0];
        gmask = ~mask_reg;
        gzero = (ma == 0) || (mb == 0);
    end

    logic signed [33:0] diff_off;
    assign diff_off = 34'(roff) - 34'(hoff);

    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rec_reg       <= '0;
            held_reg      <= '0;
            obuf_reg      <= '0;
            have_held_reg <= 1'b0;
            done_reg      <= 1'b0;
            npo_reg       <= '0;
            emitted_reg   <= '0;
            ovalid_reg    <= 1'b0;
            any_reg       <= 1'b0;
            drem_reg      <= '0;
            dden_reg      <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= '0;
            fidx_reg      <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        rec_reg   <= in_data;
                        any_reg   <= 1'b0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    // Decide what this record does.
                    if (done_reg)
                        state_reg <= ST_WAIT;
                    else if (!have_held_reg)
                    begin
                        npo_reg     <= start_ext;
                        emitted_reg <= '0;
                        if (cnt_eff == 0 || roff > start_ext)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_ENDM;
                        end
                        else
                            state_reg <= ST_TAIL;
                    end
                    else if (emitted_reg < cnt_eff && roff > npo_reg)
                    begin
                        // Start weight division: ((p - a) << WB) / d, where
                        // p - a is below d and serves as the first remainder.
                        drem_reg  <= npo_reg - hoff;
                        dden_reg  <= diff_off[32:0];
                        quo_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                        state_reg <= ST_TAIL;
                end
                ST_DIV:
                begin
                    // The quotient stays below 2^WB since p < b.
                    logic [33:0] trial;
                    trial = {drem_reg, 1'b0} - {1'b0, dden_reg};
                    if (!trial[33])
                    begin
                        drem_reg <= trial[32:0];
                        quo_reg  <= {quo_reg[WB-1:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= {drem_reg[31:0], 1'b0};
                        quo_reg  <= {quo_reg[WB-1:0], 1'b0};
                    end
                    if (dcnt_reg == CW'(WB - 1))
                    begin
                        fidx_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                ST_MUL:
                begin
                    // One field per cycle through the shared multiplier, once
                    // the output register no longer holds an untaken result.
                    if (!ovalid_reg || out_ready)
                    begin
                        obuf_reg.out_offset     <= npo_reg[31:0];
                        obuf_reg.out_end_marker <= 1'b0;
                        obuf_reg.out_final      <= 1'b0;
                        case (fidx_reg)
                            3'd0: obuf_reg.out_co2      <= mres[15:0];
                            3'd1: obuf_reg.out_temp     <= mres[15:0];
                            3'd2: obuf_reg.out_humidity <= mres[15:0];
                            3'd3: obuf_reg.out_voc <= gzero ? 16'd0 :
                                (mres[15:0] | ((held_reg.in_voc | rec_reg.in_voc) & gmask));
                            3'd4: obuf_reg.out_nox <= gzero ? 16'd0 :
                                (mres[15:0] | ((held_reg.in_nox | rec_reg.in_nox) & gmask));
                            3'd5: obuf_reg.out_pressure <= mres[17:0];
                            3'd6: obuf_reg.out_pm <= (ma < 0 || mb < 0) ? -16'sd1 : mres[15:0];
                            default: ;
                        endcase
                        if (fidx_reg == 3'd6)
                            state_reg <= ST_EMIT;
                        fidx_reg <= fidx_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    // Show the point once the output register is free.
                    if (!ovalid_reg || out_ready)
                    begin
                        logic [6:0] ne;
                        ne = emitted_reg + 1'b1;
                        ovalid_reg  <= 1'b1;
                        any_reg     <= 1'b1;
                        emitted_reg <= ne;
                        npo_reg     <= npo_reg + 33'(stp_eff);
                        if (ne >= cnt_eff)
                        begin
                            obuf_reg.out_final <= 1'b1;
                            done_reg  <= 1'b1;
                            state_reg <= ST_WAIT;
                        end
                        else
                            state_reg <= ST_CHECK;
                    end
                end
                ST_TAIL:
                begin
                    // Take the record as held; emit it if it lies on a point.
                    if (!ovalid_reg || out_ready)
                    begin
                        held_reg      <= rec_reg;
                        have_held_reg <= 1'b1;
                        state_reg     <= ST_ENDM;
                        if (emitted_reg < cnt_eff && roff == npo_reg)
                        begin
                            ovalid_reg <= 1'b1;
                            obuf_reg   <= {rec_reg.in_offset, rec_reg.in_co2,
                                rec_reg.in_temp, rec_reg.in_humidity, rec_reg.in_voc,
                                rec_reg.in_nox, rec_reg.in_pressure, rec_reg.in_pm,
                                1'b0, (emitted_reg + 7'd1 >= cnt_eff)};
                            emitted_reg <= emitted_reg + 1'b1;
                            npo_reg     <= npo_reg + 33'(stp_eff);
                            if (emitted_reg + 7'd1 >= cnt_eff)
                                done_reg <= 1'b1;
                        end
                        else if (emitted_reg >= cnt_eff)
                        begin
                            done_reg <= 1'b1;
                            if (any_reg)
                                obuf_reg.out_final <= 1'b1;
                        end
                    end
                end
                ST_ENDM:
                begin
                    // Early end marker when the data ends with points owed.
                    if (!ovalid_reg || out_ready)
                    begin
                        if (rec_reg.in_last && !done_reg)
                        begin
                            ovalid_reg <= 1'b1;
                            obuf_reg   <= '0;
                            obuf_reg.out_end_marker <= 1'b1;
                            obuf_reg.out_final      <= 1'b1;
                        end
                        state_reg <= ST_WAIT;
                    end
                end
                default:
                begin
                    // Finish the record; in_last re-arms for a new query.
                    if (rec_reg.in_last)
                    begin
                        have_held_reg <= 1'b0;
                        emitted_reg   <= '0;
                        done_reg      <= 1'b0;
                        npo_reg       <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // No request is accepted while the sequencer is busy.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("in_ready outside idle");
    // The emitted count never exceeds the bound.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= 7'(MAX_POINTS))
        else $error("point count overflow");
    // A pending result stays shown until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");
    // An end marker is always the final result.
    a_endm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.out_end_marker) |-> out_data.out_final)
        else $error("end marker not final");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the time series resampler.
// Feeds queries of mostly time-ordered records under several register settings,
// predicts every grid point in the testbench and compares each output
// request field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import tsr_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  LONG_HOLD   = 600;
    localparam int  RANDOM_RECS = 360;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_rec_t     in_data;
    logic        out_valid;
    logic        out_ready;
    out_rec_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    time_series_resampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Records waiting to be sent and grid points waiting to come back.
    in_rec_t  pending_recs[$];
    out_rec_t expected_pts[$];

    int errors;
    int recs_sent;
    int pts_seen;
    int markers_seen;
    int cycles;
    int hold_req;
    int hold_seen;
    bit send_burst;
    bit recv_burst;

    // Predictor copy of the registers and the resampling state.
    logic signed [31:0] p_start;
    logic [16:0]        p_step;
    logic [6:0]         p_count;
    logic [15:0]        p_mask;
    in_rec_t            p_held;
    bit                 p_have_held;
    longint             p_next_pt;
    int                 p_emitted;
    bit                 p_done;

    function automatic longint blend(longint a, longint b, longint w);
        return a + ((b - a) * w) / (longint'(1) << WEIGHT_BITS_DEF);
    endfunction

    // Gas words blend only their index bits; flags of both ends are merged.
    function automatic logic [15:0] blend_gas(logic [15:0] a, logic [15:0] b, longint w);
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic [15:0]        flags;
        logic [15:0]        mixed;
        va = a & p_mask;
        vb = b & p_mask;
        flags = (a | b) & ~p_mask;
        if (va == 0 || vb == 0)
            return 16'd0;
        mixed = 16'(blend(longint'(va), longint'(vb), w));
        return mixed | flags;
    endfunction

    // Work out the grid points that one accepted record closes.
    function automatic void resample_record(in_rec_t r);
        out_rec_t pts[$];
        out_rec_t o;
        int       cnt;
        longint   stp;
        longint   roff;
        longint   d;
        longint   w;
        roff = longint'(r.in_offset);
        if (!p_done) begin
            cnt = (p_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(p_count);
            stp = (p_step == 0) ? 1 : longint'(p_step);
            if (!p_have_held) begin
                p_next_pt = longint'(p_start);
                p_emitted = 0;
                if (cnt == 0 || roff > p_next_pt)
                    p_done = 1;
            end
            else begin
                while (p_emitted < cnt && roff > p_next_pt) begin
                    d = roff - longint'(p_held.in_offset);
                    w = (d > 0) ? ((p_next_pt - longint'(p_held.in_offset))
                                   <<< WEIGHT_BITS_DEF) / d : 0;
                    o = '0;
                    o.out_offset   = p_next_pt[31:0];
                    o.out_co2      = 16'(blend(p_held.in_co2, r.in_co2, w));
                    o.out_temp     = 16'(blend(p_held.in_temp, r.in_temp, w));
                    o.out_humidity = 16'(blend(p_held.in_humidity, r.in_humidity, w));
                    o.out_voc      = blend_gas(p_held.in_voc, r.in_voc, w);
                    o.out_nox      = blend_gas(p_held.in_nox, r.in_nox, w);
                    o.out_pressure = 18'(blend(p_held.in_pressure, r.in_pressure, w));
                    o.out_pm       = (p_held.in_pm < 0 || r.in_pm < 0) ? -16'sd1
                                   : 16'(blend(p_held.in_pm, r.in_pm, w));
                    pts.push_back(o);
                    p_emitted++;
                    p_next_pt += stp;
                end
            end
            if (!p_done) begin
                p_held = r;
                p_have_held = 1;
                // A record sitting exactly on a grid point is copied.
                if (p_emitted < cnt && roff == p_next_pt) begin
                    o = '0;
                    o.out_offset   = r.in_offset;
                    o.out_co2      = r.in_co2;
                    o.out_temp     = r.in_temp;
                    o.out_humidity = r.in_humidity;
                    o.out_voc      = r.in_voc;
                    o.out_nox      = r.in_nox;
                    o.out_pressure = r.in_pressure;
                    o.out_pm       = r.in_pm;
                    pts.push_back(o);
                    p_emitted++;
                    p_next_pt += stp;
                end
                if (p_emitted >= cnt) begin
                    p_done = 1;
                    if (pts.size() > 0)
                        pts[pts.size() - 1].out_final = 1'b1;
                end
            end
            // Data ran out while points are still owed.
            if (r.in_last && !p_done) begin
                o = '0;
                o.out_end_marker = 1'b1;
                o.out_final = 1'b1;
                pts.push_back(o);
                p_done = 1;
            end
        end
        if (r.in_last) begin
            p_have_held = 0;
            p_emitted = 0;
            p_done = 0;
            p_next_pt = 0;
        end
        foreach (pts[i])
            expected_pts.push_back(pts[i]);
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle counter with a run limit.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Driver: presents pending records, with a random gap after each one outside burst mode.
    int send_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else if (!(in_valid && !in_ready)) begin
            if (in_valid) begin
                resample_record(in_data);
                recs_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_recs.size() > 0) begin
                in_data  <= pending_recs.pop_front();
                in_valid <= 1'b1;
                send_gap <= send_burst ? 0 : $urandom_range(0, 15);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output request and stalls at random.
    int recv_wait;
    always @(posedge clk or negedge rst_n) begin
        int       w;
        out_rec_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            hold_seen <= 0;
        end
        else begin
            w = (recv_wait > 0) ? recv_wait - 1 : 0;
            if (out_valid && out_ready) begin
                if (expected_pts.size() == 0) begin
                    $error("output request with no point expected");
                    errors++;
                end
                else begin
                    e = expected_pts.pop_front();
                    compare_field("out_offset", e.out_offset, out_data.out_offset);
                    compare_field("out_co2", e.out_co2, out_data.out_co2);
                    compare_field("out_temp", e.out_temp, out_data.out_temp);
                    compare_field("out_humidity", e.out_humidity, out_data.out_humidity);
                    compare_field("out_voc", e.out_voc, out_data.out_voc);
                    compare_field("out_nox", e.out_nox, out_data.out_nox);
                    compare_field("out_pressure", e.out_pressure, out_data.out_pressure);
                    compare_field("out_pm", e.out_pm, out_data.out_pm);
                    compare_field("out_end_marker", e.out_end_marker,
                                  out_data.out_end_marker);
                    compare_field("out_final", e.out_final, out_data.out_final);
                end
                if (out_data.out_end_marker)
                    markers_seen++;
                else
                    pts_seen++;
                w = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                w = LONG_HOLD;
            end
            recv_wait <= w;
            out_ready <= (w == 0);
        end
    end

    // Register writes, mirrored into the predictor.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_START: p_start = val;
            REG_STEP:  p_step  = val[16:0];
            REG_COUNT: p_count = val[6:0];
            default:   p_mask  = val[15:0];
        endcase
    endtask

    task automatic set_regs(logic [31:0] start, logic [31:0] stp, logic [31:0] cnt,
                            logic [31:0] mask);
        write_reg(REG_START, start);
        write_reg(REG_STEP, stp);
        write_reg(REG_COUNT, cnt);
        write_reg(REG_MASK, mask);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every record is taken and every point has come back.
    task automatic wait_idle();
        while (pending_recs.size() > 0 || in_valid || expected_pts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic in_rec_t make_rec(longint off, bit last);
        in_rec_t r;
        r.in_offset   = off[31:0];
        r.in_co2      = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        r.in_temp     = 16'($urandom);
        r.in_humidity = 16'($urandom);
        r.in_voc      = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        r.in_nox      = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        r.in_pressure = 18'($urandom);
        r.in_pm       = 16'($urandom);
        r.in_last     = last;
        return r;
    endfunction

    // One query: records mostly ascend from at or below the start offset, with rare
    // jumps to near the start, sometimes exactly on the grid, ending with the last flag.
    task automatic queue_query(int n, longint start, longint stp);
        longint off;
        bit     aligned;
        aligned = ($urandom_range(0, 3) == 0);
        off = aligned ? start : start - $urandom_range(0, int'(stp));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                off = start + $signed($urandom_range(0, 400)) - 200;
            if (off > 64'sd2147483647)
                off = 64'sd2147483647;
            pending_recs.push_back(make_rec(off, i == n - 1));
            off += aligned ? stp * $urandom_range(1, 3) : $urandom_range(1, 3 * int'(stp));
        end
    endtask

    initial begin
        longint start;
        int     stp;
        int     cnt;
        int     made;
        hold_req = 0;
        send_burst = 0;
        recv_burst = 0;
        cfg_we = 1'b0;
        cfg_index = REG_START;
        cfg_data = '0;
        p_start = 0;
        p_step = 60;
        p_count = 64;
        p_mask = 511;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: copy, brackets, query before data, early end, trailing record.
        set_regs(0, 60, 4, 511);
        pending_recs.push_back(make_rec(-10, 0));
        pending_recs.push_back(make_rec(0, 0));
        pending_recs.push_back(make_rec(30, 0));
        pending_recs.push_back(make_rec(200, 0));
        pending_recs.push_back(make_rec(300, 1));
        pending_recs.push_back(make_rec(100, 1));
        pending_recs.push_back(make_rec(-5, 1));
        pending_recs.push_back(make_rec(-50, 0));
        pending_recs.push_back(make_rec(70, 1));
        wait_idle();
        // Extremes: lowest start, zero step, count zero and above the maximum.
        set_regs(32'h8000_0000, 0, 127, 16'hFFFF);
        pending_recs.push_back(make_rec(-64'sd2147483648, 0));
        pending_recs.push_back(make_rec(-64'sd2147483600, 0));
        pending_recs.push_back(make_rec(-64'sd2147483500, 1));
        wait_idle();
        set_regs(32'h7FFF_FFFF, 86400, 0, 0);
        pending_recs.push_back(make_rec(0, 0));
        pending_recs.push_back(make_rec(64'sd2147483647, 1));
        wait_idle();
        set_regs(32'h7FFF_FF00, 86400, 3, 16'h00FF);
        pending_recs.push_back(make_rec(64'sd2147483000, 0));
        pending_recs.push_back(make_rec(64'sd2147483647, 1));
        wait_idle();

        // Random phases with long receiver hold-offs, the first always among them.
        made = 0;
        while (made < RANDOM_RECS) begin
            start = $signed($urandom);
            if ($urandom_range(0, 1)) start = $signed($urandom_range(0, 100000)) - 50000;
            stp = ($urandom_range(0, 9) == 0) ? 86400 : $urandom_range(1, 200);
            cnt = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
            set_regs(start[31:0], stp, cnt, $urandom_range(0, 65535));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (made == 0 || $urandom_range(0, 5) == 0)
                hold_req++;
            for (int q = 0; q < 3; q++) begin
                int n;
                n = $urandom_range(2, 10);
                queue_query(n, start, stp);
                made += n;
            end
            wait_idle();
        end

        $display("Sent %0d records in directed and random queries; checked %0d points",
                 recs_sent, pts_seen);
        $display("and %0d end markers across extreme and random register settings.",
                 markers_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
